FILE: sv/dtl_pkg.sv
// ============================================================================
// dtl_pkg
// Shared types and character codes for the description text lexer.
// ============================================================================
package dtl_pkg;

    localparam int LINE_W = 16;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    localparam logic [3:0] KIND_NAME      = 4'd0;
    localparam logic [3:0] KIND_LINK      = 4'd1;
    localparam logic [3:0] KIND_LPAREN    = 4'd2;
    localparam logic [3:0] KIND_RPAREN    = 4'd3;
    localparam logic [3:0] KIND_LBRACE    = 4'd4;
    localparam logic [3:0] KIND_RBRACE    = 4'd5;
    localparam logic [3:0] KIND_SEMICOLON = 4'd6;
    localparam logic [3:0] KIND_COLON     = 4'd7;
    localparam logic [3:0] KIND_COMMA     = 4'd8;

    typedef enum logic [6:0] {
        MODE_IDLE    = 7'b0000001,
        MODE_NAME    = 7'b0000010,
        MODE_QUOTE   = 7'b0000100,
        MODE_ESC     = 7'b0001000,
        MODE_CHAR    = 7'b0010000,
        MODE_DASH    = 7'b0100000,
        MODE_COMMENT = 7'b1000000
    } lex_mode_t;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       final_byte;
    } in_t;

    typedef struct packed {
        logic              has_char;
        logic [7:0]        text_char;
        logic              token_done;
        logic [3:0]        token_kind;
        logic [LINE_W-1:0] line_number;
        logic              parse_error;
        logic              last;
    } out_t;

    // Lexer state carried between bytes.
    typedef struct packed {
        lex_mode_t         mode;
        logic              nonempty;
        logic              error;
        logic [LINE_W-1:0] line_count;
    } lex_state_t;

    // Everything one byte produces: up to three results and the next state.
    typedef struct packed {
        logic [1:0]     count;
        out_t [2:0]     items;
        lex_state_t     state;
    } step_res_t;

endpackage

FILE: sv/dtl_step.sv
// ============================================================================
// dtl_step
// Lexes one byte against the current state; gives up to three results.
// ============================================================================
module dtl_step
    import dtl_pkg::*;
(
    input  in_t        item,
    input  lex_state_t state,
    output step_res_t  res
);

    typedef struct packed {
        logic [1:0]        count;
        out_t [2:0]        items;
        logic [LINE_W-1:0] line_no;
    } acc_t;

    typedef struct packed {
        lex_mode_t  mode;
        logic       ne_wr;
        logic       ne_val;
        logic       emit;
        logic       done;
        logic [3:0] kind;
        logic       fail;
    } idle_t;

    function automatic acc_t put_res(acc_t a, logic has, logic [7:0] ch, logic done,
                                     logic [3:0] kind, logic err);
        acc_t r;
        out_t o;
        r             = a;
        o.has_char    = has;
        o.text_char   = ch;
        o.token_done  = done;
        o.token_kind  = kind;
        o.line_number = a.line_no;
        o.parse_error = err;
        o.last        = 1'b0;
        if (a.count != 2'd3) begin
            r.items[a.count] = o;
            r.count          = a.count + 2'd1;
        end
        return r;
    endfunction

    function automatic logic is_name(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || (c == CH_UNDER);
    endfunction

    function automatic idle_t idle_lex(logic [7:0] c);
        idle_t r;
        r      = '0;
        r.mode = MODE_IDLE;
        r.kind = KIND_NAME;
        if (is_name(c)) begin
            r.mode   = MODE_NAME;
            r.ne_wr  = 1'b1;
            r.ne_val = 1'b1;
            r.emit   = 1'b1;
        end else if (c == CH_SQUOTE) begin
            r.mode  = MODE_CHAR;
            r.ne_wr = 1'b1;
        end else if (c == CH_DQUOTE) begin
            r.mode  = MODE_QUOTE;
            r.ne_wr = 1'b1;
        end else if (c == CH_DASH) begin
            r.mode = MODE_DASH;
            r.emit = 1'b1;
        end else begin
            case (c)
                CH_LPAREN: begin r.emit = 1'b1; r.done = 1'b1; r.kind = KIND_LPAREN; end
                CH_RPAREN: begin r.emit = 1'b1; r.done = 1'b1; r.kind = KIND_RPAREN; end
                CH_LBRACE: begin r.emit = 1'b1; r.done = 1'b1; r.kind = KIND_LBRACE; end
                CH_RBRACE: begin r.emit = 1'b1; r.done = 1'b1; r.kind = KIND_RBRACE; end
                CH_SEMI:   begin r.emit = 1'b1; r.done = 1'b1; r.kind = KIND_SEMICOLON; end
                CH_COLON:  begin r.emit = 1'b1; r.done = 1'b1; r.kind = KIND_COLON; end
                CH_COMMA:  begin r.emit = 1'b1; r.done = 1'b1; r.kind = KIND_COMMA; end
                CH_SPACE, CH_TAB, CH_CR, CH_NUL: begin end
                CH_HASH:   r.mode = MODE_COMMENT;
                default:   r.fail = 1'b1;
            endcase
        end
        return r;
    endfunction

    logic [7:0]        c;
    logic              fin;
    logic              is_lf;
    logic              line_end;
    logic [LINE_W-1:0] line_no;
    acc_t              acc;
    idle_t             idl;
    lex_mode_t         mode;
    logic              ne;
    logic              err;
    logic              do_idle;
    logic [LINE_W-1:0] line_cnt;

    assign c        = item.source_byte;
    assign fin      = item.final_byte;
    assign is_lf    = (c == CH_LF);
    assign line_end = is_lf || (c == CH_SEMI) || (c == CH_RBRACE) || fin;
    assign line_no  = (state.line_count == '1) ? state.line_count
                                               : state.line_count + 1'b1;
    assign idl      = idle_lex(c);

    always_comb begin
        acc         = '0;
        acc.line_no = line_no;
        mode        = state.mode;
        ne          = state.nonempty;
        err         = state.error;
        do_idle     = 1'b0;
        line_cnt    = state.line_count;

        if (!err) begin
            if (!is_lf) begin
                unique case (mode)
                    MODE_NAME: begin
                        if (is_name(c)) begin
                            acc = put_res(acc, 1'b1, c, 1'b0, KIND_NAME, 1'b0);
                        end else begin
                            acc     = put_res(acc, 1'b0, 8'h00, 1'b1, KIND_NAME, 1'b0);
                            do_idle = 1'b1;
                        end
                    end
                    MODE_QUOTE: begin
                        if (c == CH_DQUOTE) begin
                            if (!ne) begin
                                acc = put_res(acc, 1'b0, 8'h00, 1'b0, KIND_NAME, 1'b1);
                                err = 1'b1;
                            end else begin
                                acc  = put_res(acc, 1'b0, 8'h00, 1'b1, KIND_NAME, 1'b0);
                                mode = MODE_IDLE;
                            end
                        end else if (c == CH_BSLASH) begin
                            mode = MODE_ESC;
                        end else begin
                            acc = put_res(acc, 1'b1, c, 1'b0, KIND_NAME, 1'b0);
                            ne  = 1'b1;
                        end
                    end
                    MODE_ESC: begin
                        acc  = put_res(acc, 1'b1, c, 1'b0, KIND_NAME, 1'b0);
                        ne   = 1'b1;
                        mode = MODE_QUOTE;
                    end
                    MODE_CHAR: begin
                        if (c == CH_SQUOTE) begin
                            if (!ne) begin
                                acc = put_res(acc, 1'b0, 8'h00, 1'b0, KIND_NAME, 1'b1);
                                err = 1'b1;
                            end else begin
                                acc  = put_res(acc, 1'b0, 8'h00, 1'b1, KIND_NAME, 1'b0);
                                mode = MODE_IDLE;
                            end
                        end else if (ne) begin
                            acc = put_res(acc, 1'b0, 8'h00, 1'b0, KIND_NAME, 1'b1);
                            err = 1'b1;
                        end else begin
                            acc = put_res(acc, 1'b1, c, 1'b0, KIND_NAME, 1'b0);
                            ne  = 1'b1;
                        end
                    end
                    MODE_DASH: begin
                        if (c == CH_GT) begin
                            acc  = put_res(acc, 1'b1, c, 1'b1, KIND_LINK, 1'b0);
                            mode = MODE_IDLE;
                        end else begin
                            acc = put_res(acc, 1'b0, 8'h00, 1'b0, KIND_NAME, 1'b1);
                            err = 1'b1;
                        end
                    end
                    MODE_COMMENT: begin end
                    default: do_idle = 1'b1;
                endcase

                if (do_idle) begin
                    mode = idl.mode;
                    if (idl.ne_wr) begin
                        ne = idl.ne_val;
                    end
                    if (idl.emit) begin
                        acc = put_res(acc, 1'b1, c, idl.done, idl.kind, 1'b0);
                    end
                    if (idl.fail) begin
                        acc = put_res(acc, 1'b0, 8'h00, 1'b0, KIND_NAME, 1'b1);
                        err = 1'b1;
                    end
                end
            end

            // Close the logical line: flush a name, abandon an open quote, flag an open char literal or dash.
            if (!err && line_end) begin
                if (mode == MODE_NAME) begin
                    acc = put_res(acc, 1'b0, 8'h00, 1'b1, KIND_NAME, 1'b0);
                end else if ((mode == MODE_QUOTE || mode == MODE_ESC) && ne) begin
                    acc = put_res(acc, 1'b0, 8'h00, 1'b0, KIND_NAME, 1'b0);
                end else if ((mode == MODE_CHAR && ne) || mode == MODE_DASH) begin
                    acc = put_res(acc, 1'b0, 8'h00, 1'b0, KIND_NAME, 1'b1);
                    err = 1'b1;
                end
                if (!err) begin
                    mode = MODE_IDLE;
                    ne   = 1'b0;
                end
            end

            if (!err && is_lf && state.line_count != '1) begin
                line_cnt = state.line_count + 1'b1;
            end

            if (acc.count != 2'd0) begin
                acc.items[acc.count - 2'd1].last = 1'b1;
            end
        end

        res.count            = acc.count;
        res.items            = acc.items;
        res.state.mode       = mode;
        res.state.nonempty   = ne;
        res.state.error      = err;
        res.state.line_count = line_cnt;
    end

endmodule

FILE: sv/dtl_obuf.sv
// ============================================================================
// dtl_obuf
// Result bank: holds up to three results of one byte, drains one per cycle while m_ready is high.
// ============================================================================
module dtl_obuf
    import dtl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  logic [1:0] load_count,
    input  out_t [2:0] load_items,
    output logic       can_load,
    output logic       m_valid,
    input  logic       m_ready,
    output out_t       m_data
);

    out_t [2:0] slot_reg;
    out_t [2:0] slot_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       pop;

    assign pop      = (cnt_reg != 2'd0) && m_ready;
    assign can_load = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_ready);
    assign m_valid  = (cnt_reg != 2'd0);
    assign m_data   = slot_reg[0];

    always_comb begin
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        if (load) begin
            slot_next = load_items;
            cnt_next  = load_count;
        end else if (pop) begin
            // advance the queue by one slot
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
            cnt_next     = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

endmodule

FILE: sv/description_text_lexer.sv
// ============================================================================
// description_text_lexer
// Streaming byte-in, token-out lexer for a small description language.
// ============================================================================
// One source byte per request enters an input register; a single combinational
// pass lexes it against the lexer state and loads up to three results into a
// result bank that drives the m_ channel one result per cycle while m_ready is
// high. A token arrives as its characters (has_char=1) closed by a result with
// token_done=1 and its kind; punctuation is one result carrying both. A result
// with has_char=0, token_done=0 and parse_error=0 tells the receiver to discard
// a quote left open at a line end. After a parse_error result the block
// swallows all further bytes without output until aresetn. The input register
// takes a new byte while the bank drains, but the held byte is lexed only once
// the bank is empty or holds one result that m_ready takes in that cycle. A
// byte's results reach m_ through the input register and then the result bank.
// ============================================================================
module description_text_lexer
    import dtl_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    // Input register: hold the request until the result bank can take its results.
    logic       in_valid_reg;
    logic       in_valid_next;
    in_t        in_data_reg;

    // Lexer state between bytes.
    lex_state_t state_reg;
    lex_state_t state_next;

    step_res_t  step;
    logic       can_load;
    logic       consume;

    dtl_step u_step (
        .item  (in_data_reg),
        .state (state_reg),
        .res   (step)
    );

    // Consume the held byte once the bank is free (or frees up this cycle).
    assign consume = in_valid_reg && can_load;
    assign s_ready = !in_valid_reg || consume;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end
        state_next = consume ? step.state : state_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg         <= 1'b0;
            state_reg.mode       <= MODE_IDLE;
            state_reg.nonempty   <= 1'b0;
            state_reg.error      <= 1'b0;
            state_reg.line_count <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
        end
    end

    // Payload: no reset, capture on every accepted request.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    dtl_obuf u_obuf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (consume),
        .load_count (step.count),
        .load_items (step.items),
        .can_load   (can_load),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
